/* hdl/mbb_pkg.sv */
// Shared types, constants and arithmetic helpers for the mosaic block binning design.
// Used by the channel interfaces and by every module under hdl but mbb_fifo; depends on nothing else.
package mbb_pkg;

  localparam int MAX_CELLS_PER_ROW = 512;
  localparam int MAX_FRAME_WIDTH   = 2048;

  localparam int PIX_W      = 16;
  localparam int ACC_W      = 22;
  localparam int ROW_W      = 11;
  localparam int QUOT_W     = 13;
  localparam int COLOUR_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int QUEUE_DEPTH = 8;
  localparam int OUT_DEPTH   = 8;

  localparam logic [3:0]  SIDE_MIN     = 4'd2;
  localparam logic [3:0]  SIDE_MAX     = 4'd8;
  localparam logic [3:0]  SIDE_RESET   = 4'd4;
  localparam logic [11:0] DIM_MIN      = 12'd2;
  localparam logic [11:0] DIM_RESET    = 12'd2048;
  localparam logic [11:0] HEIGHT_MAX   = 12'd2048;

  localparam logic [15:0] VALUE_MAX    = 16'hFFFF;
  localparam logic [9:0]  COLOUR_CLIP  = 10'd1023;
  localparam logic [9:0]  BLUE_LIMIT   = 10'd10;
  localparam logic [9:0]  RED_LIMIT    = 10'd1013;
  localparam logic [7:0]  COLOUR_FULL  = 8'd255;
  localparam logic [18:0] GREY_RECIP   = 19'd262401;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_SIDE    = 2'd0,
    REG_BIN_MODE     = 2'd1,
    REG_FRAME_WIDTH  = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } mbb_reg_t;

  typedef enum logic {
    MODE_MAX  = 1'b0,
    MODE_MEAN = 1'b1
  } mbb_mode_t;

  typedef struct packed {
    logic [3:0]            cell_side;
    mbb_mode_t             bin_mode;
    logic [CFG_DATA_W-1:0] frame_width;
    logic [CFG_DATA_W-1:0] frame_height;
  } mbb_cfg_t;

  typedef struct packed {
    logic first;
    logic last;
    logic frame_end;
  } mbb_flags_t;

  typedef struct packed {
    logic [PIX_W-1:0]    binned_value;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic                frame_end;
  } mbb_result_t;

  function automatic int cell_bits(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic logic [3:0] side_clamp(logic [3:0] s);
    logic [3:0] r;
    r = s;
    if (s < SIDE_MIN) r = SIDE_MIN;
    else if (s > SIDE_MAX) r = SIDE_MAX;
    return r;
  endfunction

  // Reciprocal of the cell side scaled by 2^15; exact for dividends below 2^12.
  function automatic logic [14:0] side_recip(logic [3:0] side);
    logic [14:0] r;
    case (side)
      4'd2:    r = 15'd16384;
      4'd3:    r = 15'd10923;
      4'd4:    r = 15'd8192;
      4'd5:    r = 15'd6554;
      4'd6:    r = 15'd5462;
      4'd7:    r = 15'd4682;
      default: r = 15'd4096;
    endcase
    return r;
  endfunction

  function automatic logic [QUOT_W-1:0] div_side(logic [QUOT_W-1:0] n, logic [3:0] side);
    logic [27:0] prod;
    prod = 28'(n) * 28'(side_recip(side));
    return prod[27:15];
  endfunction

  // Reciprocal of the cell area scaled by 2^28; exact for every 22-bit sum.
  function automatic logic [26:0] mean_recip(logic [3:0] side);
    logic [26:0] r;
    case (side)
      4'd2:    r = 27'd67108864;
      4'd3:    r = 27'd29826162;
      4'd4:    r = 27'd16777216;
      4'd5:    r = 27'd10737419;
      4'd6:    r = 27'd7456541;
      4'd7:    r = 27'd5478275;
      default: r = 27'd4194304;
    endcase
    return r;
  endfunction

endpackage

/* hdl/mbb_if.sv */
// Valid/ready channel interfaces for pixels, results and register writes.
// Depends on mbb_pkg for the field widths.
interface mbb_pix_if;
  import mbb_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             frame_start;
  modport source (output valid, pixel_value, frame_start, input ready);
  modport sink (input valid, pixel_value, frame_start, output ready);
endinterface

interface mbb_res_if;
  import mbb_pkg::*;
  logic                valid;
  logic                ready;
  logic [PIX_W-1:0]    binned_value;
  logic [COLOUR_W-1:0] red;
  logic [COLOUR_W-1:0] green;
  logic [COLOUR_W-1:0] blue;
  logic                frame_end;
  modport source (output valid, binned_value, red, green, blue, frame_end, input ready);
  modport sink (input valid, binned_value, red, green, blue, frame_end, output ready);
endinterface

interface mbb_cfg_if;
  import mbb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/mbb_fifo.sv */
// Small first-in first-out queue held in registers, with an occupancy count.
// The writer checks the count before pushing. Depends on nothing else.
module mbb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  output logic                       pop_valid,
  input  logic                       pop_ready,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             pop;

  assign pop_valid = (count != NW'(0));
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + NW'(push) - NW'(pop);
    end
  end

endmodule

/* hdl/mbb_front.sv */
// Front end: accepts pixels, tracks the frame position and classifies each pixel
// into its cell. Depends on mbb_pkg and mbb_pix_if.
module mbb_front #(
  parameter int MAX_CELLS_PER_ROW = mbb_pkg::MAX_CELLS_PER_ROW,
  parameter int MAX_FRAME_WIDTH   = mbb_pkg::MAX_FRAME_WIDTH
) (
  input  logic                                               clk,
  input  logic                                               rst,
  mbb_pix_if.sink                                            pix,
  input  mbb_pkg::mbb_cfg_t                                  cfg_regs,
  input  logic [$clog2(mbb_pkg::QUEUE_DEPTH+1)-1:0]          q_count,
  output logic                                               q_push,
  output logic [mbb_pkg::cell_bits(MAX_CELLS_PER_ROW)-1:0]   q_cell,
  output logic [mbb_pkg::PIX_W-1:0]                          q_pix,
  output mbb_pkg::mbb_flags_t                                q_flags
);
  import mbb_pkg::*;

  localparam int XW = $clog2(MAX_FRAME_WIDTH);
  localparam int CW = cell_bits(MAX_CELLS_PER_ROW);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [XW-1:0]     column_count;
  logic [ROW_W-1:0]  row_count;
  logic [3:0]        side;
  logic [12:0]       width_eff;
  logic [11:0]       height_eff;
  logic [XW-1:0]     col_cur;
  logic [ROW_W-1:0]  row_cur;
  logic [XW-1:0]     x;
  logic [ROW_W-1:0]  y;
  logic [XW:0]       col_inc;
  logic [ROW_W:0]    row_inc;
  logic              col_wrap;
  logic [XW-1:0]     column_count_next;
  logic [ROW_W-1:0]  row_count_next;
  logic [NW+1:0]     occupancy;
  logic              accept;

  logic              s1_v;
  logic [XW-1:0]     s1_x;
  logic [ROW_W-1:0]  s1_y;
  logic [PIX_W-1:0]  s1_pix;
  logic [QUOT_W-1:0] cells_w_full;
  logic [QUOT_W-1:0] cells_w;

  logic              s2_v;
  logic [XW-1:0]     s2_x;
  logic [ROW_W-1:0]  s2_y;
  logic [PIX_W-1:0]  s2_pix;
  logic [QUOT_W-1:0] s2_qx;
  logic [QUOT_W-1:0] s2_qy;
  logic [QUOT_W-1:0] s2_cw;
  logic [QUOT_W-1:0] s2_ch;
  logic [16:0]       base_x;
  logic [16:0]       base_y;
  logic              keep;

  assign side = side_clamp(cfg_regs.cell_side);

  always_comb begin
    width_eff = {1'b0, cfg_regs.frame_width};
    if (cfg_regs.frame_width < DIM_MIN) width_eff = 13'(DIM_MIN);
    else if ({1'b0, cfg_regs.frame_width} > 13'(MAX_FRAME_WIDTH)) width_eff = 13'(MAX_FRAME_WIDTH);
    height_eff = cfg_regs.frame_height;
    if (cfg_regs.frame_height < DIM_MIN) height_eff = DIM_MIN;
    else if (cfg_regs.frame_height > HEIGHT_MAX) height_eff = HEIGHT_MAX;
  end

  always_comb begin
    col_cur = pix.frame_start ? '0 : column_count;
    row_cur = pix.frame_start ? '0 : row_count;
    x = (13'(col_cur) >= width_eff) ? '0 : col_cur;
    y = (12'(row_cur) >= height_eff) ? '0 : row_cur;
    col_inc  = {1'b0, x} + (XW + 1)'(1);
    row_inc  = {1'b0, y} + (ROW_W + 1)'(1);
    col_wrap = (13'(col_inc) >= width_eff);
    column_count_next = col_wrap ? '0 : col_inc[XW-1:0];
    row_count_next    = y;
    if (col_wrap) begin
      row_count_next = (12'(row_inc) >= height_eff) ? '0 : row_inc[ROW_W-1:0];
    end
  end

  assign occupancy = (NW + 2)'(q_count) + (NW + 2)'(s1_v) + (NW + 2)'(s2_v);
  assign pix.ready = (occupancy < (NW + 2)'(QUEUE_DEPTH));
  assign accept    = pix.valid && pix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
    end else begin
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end
      s1_v <= accept;
      s2_v <= s1_v;
    end
  end

  assign cells_w_full = div_side(width_eff, side);
  assign cells_w = (cells_w_full > QUOT_W'(MAX_CELLS_PER_ROW)) ? QUOT_W'(MAX_CELLS_PER_ROW)
                                                                : cells_w_full;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x   <= x;
      s1_y   <= y;
      s1_pix <= pix.pixel_value;
    end
    s2_x   <= s1_x;
    s2_y   <= s1_y;
    s2_pix <= s1_pix;
    s2_qx  <= div_side(QUOT_W'(s1_x), side);
    s2_qy  <= div_side(QUOT_W'(s1_y), side);
    s2_cw  <= cells_w;
    s2_ch  <= div_side({1'b0, height_eff}, side);
  end

  always_comb begin
    base_x = 17'(s2_qx) * 17'(side);
    base_y = 17'(s2_qy) * 17'(side);
    keep   = (s2_qx < s2_cw) && (s2_qy < s2_ch);
    q_flags.first     = (base_x == 17'(s2_x)) && (base_y == 17'(s2_y));
    q_flags.last      = ((base_x + 17'(side) - 17'd1) == 17'(s2_x))
                        && ((base_y + 17'(side) - 17'd1) == 17'(s2_y));
    q_flags.frame_end = (s2_qx == s2_cw - QUOT_W'(1)) && (s2_qy == s2_ch - QUOT_W'(1));
  end

  assign q_push = s2_v && keep;
  assign q_cell = s2_qx[CW-1:0];
  assign q_pix  = s2_pix;

endmodule

/* hdl/mbb_back.sv */
// Back end: updates the per-column cell accumulators, forms the maximum or mean of
// each finished cell and its false colour, and buffers results. Depends on mbb_pkg,
// mbb_res_if and mbb_fifo.
module mbb_back #(
  parameter int MAX_CELLS_PER_ROW = mbb_pkg::MAX_CELLS_PER_ROW
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  mbb_pkg::mbb_cfg_t                                cfg_regs,
  input  logic                                             pop_valid,
  output logic                                             pop_ready,
  input  logic [mbb_pkg::cell_bits(MAX_CELLS_PER_ROW)-1:0] pop_cell,
  input  logic [mbb_pkg::PIX_W-1:0]                        pop_pix,
  input  mbb_pkg::mbb_flags_t                              pop_flags,
  mbb_res_if.source                                        res
);
  import mbb_pkg::*;

  localparam int CW = cell_bits(MAX_CELLS_PER_ROW);
  localparam int NW = $clog2(OUT_DEPTH + 1);
  localparam int RW = $bits(mbb_result_t);

  logic [ACC_W-1:0] acc_mem [MAX_CELLS_PER_ROW];
  logic [ACC_W-1:0] ram_q;

  logic [3:0]       side;
  logic             pop;
  logic [NW+2:0]    occupancy;
  logic [NW-1:0]    oq_count;

  logic             b_v;
  logic [CW-1:0]    b_cell;
  logic [PIX_W-1:0] b_pix;
  mbb_flags_t       b_flags;
  logic             fwd_v;
  logic [CW-1:0]    fwd_cell;
  logic [ACC_W-1:0] fwd_data;
  logic [ACC_W-1:0] acc_old;
  logic [ACC_W-1:0] acc_new;

  logic             r1_v;
  logic [ACC_W-1:0] r1_acc;
  logic             r1_fend;
  logic [48:0]      mean_prod;

  logic             r2_v;
  logic [ACC_W-1:0] r2_acc;
  logic [20:0]      r2_mean;
  logic             r2_fend;
  logic [PIX_W-1:0] value;
  logic [9:0]       clip;
  logic [17:0]      scaled;
  logic [36:0]      grey_prod;

  logic             r3_v;
  logic [PIX_W-1:0] r3_value;
  logic [9:0]       r3_clip;
  logic [7:0]       r3_grey;
  logic             r3_fend;
  mbb_result_t      result;
  mbb_result_t      oq_out;
  logic [RW-1:0]    oq_data;

  assign side = side_clamp(cfg_regs.cell_side);

  assign occupancy = (NW + 3)'(oq_count) + (NW + 3)'(b_v) + (NW + 3)'(r1_v)
                     + (NW + 3)'(r2_v) + (NW + 3)'(r3_v);
  assign pop_ready = (occupancy < (NW + 3)'(OUT_DEPTH));
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (pop) begin
      ram_q <= acc_mem[pop_cell];
    end
    if (b_v) begin
      acc_mem[b_cell] <= acc_new;
    end
  end

  // The entry written in the previous cycle was read before the write landed.
  always_comb begin
    acc_old = (fwd_v && (fwd_cell == b_cell)) ? fwd_data : ram_q;
    if (b_flags.first) begin
      acc_new = ACC_W'(b_pix);
    end else if (cfg_regs.bin_mode == MODE_MEAN) begin
      acc_new = acc_old + ACC_W'(b_pix);
    end else begin
      acc_new = (ACC_W'(b_pix) > acc_old) ? ACC_W'(b_pix) : acc_old;
    end
  end

  assign mean_prod = 49'(r1_acc) * 49'(mean_recip(side));

  always_comb begin
    if (cfg_regs.bin_mode == MODE_MEAN) begin
      value = (r2_mean > 21'(VALUE_MAX)) ? VALUE_MAX : r2_mean[PIX_W-1:0];
    end else begin
      value = (r2_acc > ACC_W'(VALUE_MAX)) ? VALUE_MAX : r2_acc[PIX_W-1:0];
    end
    clip      = (value > PIX_W'(COLOUR_CLIP)) ? COLOUR_CLIP : value[9:0];
    scaled    = {clip, 8'd0} - 18'(clip);
    grey_prod = 37'(scaled) * 37'(GREY_RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v   <= 1'b0;
      fwd_v <= 1'b0;
      r1_v  <= 1'b0;
      r2_v  <= 1'b0;
      r3_v  <= 1'b0;
    end else begin
      b_v  <= pop;
      r1_v <= b_v && b_flags.last;
      r2_v <= r1_v;
      r3_v <= r2_v;
      if (b_v) begin
        fwd_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_cell  <= pop_cell;
      b_pix   <= pop_pix;
      b_flags <= pop_flags;
    end
    if (b_v) begin
      fwd_cell <= b_cell;
      fwd_data <= acc_new;
    end
    r1_acc   <= acc_new;
    r1_fend  <= b_flags.frame_end;
    r2_acc   <= r1_acc;
    r2_mean  <= mean_prod[48:28];
    r2_fend  <= r1_fend;
    r3_value <= value;
    r3_clip  <= clip;
    r3_grey  <= grey_prod[35:28];
    r3_fend  <= r2_fend;
  end

  always_comb begin
    result.binned_value = r3_value;
    result.frame_end    = r3_fend;
    if (r3_clip <= BLUE_LIMIT) begin
      result.red   = '0;
      result.green = '0;
      result.blue  = COLOUR_FULL;
    end else if (r3_clip >= RED_LIMIT) begin
      result.red   = COLOUR_FULL;
      result.green = '0;
      result.blue  = '0;
    end else begin
      result.red   = r3_grey;
      result.green = r3_grey;
      result.blue  = r3_grey;
    end
  end

  mbb_fifo #(
    .WIDTH (RW),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (r3_v),
    .push_data (result),
    .pop_valid (res.valid),
    .pop_ready (res.ready),
    .pop_data  (oq_data),
    .count     (oq_count)
  );

  assign oq_out           = oq_data;
  assign res.binned_value = oq_out.binned_value;
  assign res.red          = oq_out.red;
  assign res.green        = oq_out.green;
  assign res.blue         = oq_out.blue;
  assign res.frame_end    = oq_out.frame_end;

endmodule

/* hdl/mosaic_block_binning_top.sv */
// Top level of the mosaic block binning design: register file, front end, cell queue
// and back end. Depends on mbb_pkg, the channel interfaces, mbb_fifo, mbb_front, mbb_back.
//
// The block takes one 16-bit pixel per clock in raster order while ready is high and
// returns one result per complete square cell once its last pixel has passed the front
// end, the cell queue, the back end and the result buffer. The sustained rate is one pixel
// per cycle, set by the read-modify-write of the accumulator line store, which reads one
// entry and writes another in each cycle; its back-to-back hazard is covered by
// forwarding. Ready falls only when the eight-entry cell queue or result buffer, with its
// items in flight, fills behind a stalled output. The accumulator store needs no clearing
// after reset, as each cell's first pixel loads it. The user must write the registers,
// via the always-ready configuration channel, only while idle; the block does not check.
module mosaic_block_binning_top #(
  parameter int MAX_CELLS_PER_ROW = mbb_pkg::MAX_CELLS_PER_ROW,
  parameter int MAX_FRAME_WIDTH   = mbb_pkg::MAX_FRAME_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  mbb_cfg_if.sink   cfg,
  mbb_pix_if.sink   pix,
  mbb_res_if.source res
);
  import mbb_pkg::*;

  localparam int CW = cell_bits(MAX_CELLS_PER_ROW);
  localparam int QW = CW + PIX_W + $bits(mbb_flags_t);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  mbb_cfg_t         cfg_regs;
  logic             q_push;
  logic [CW-1:0]    q_cell;
  logic [PIX_W-1:0] q_pix;
  mbb_flags_t       q_flags;
  logic [NW-1:0]    q_count;
  logic             q_pop_valid;
  logic             q_pop_ready;
  logic [QW-1:0]    q_pop_data;
  logic [CW-1:0]    b_cell;
  logic [PIX_W-1:0] b_pix;
  mbb_flags_t       b_flags;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.cell_side    <= SIDE_RESET;
      cfg_regs.bin_mode     <= MODE_MAX;
      cfg_regs.frame_width  <= DIM_RESET;
      cfg_regs.frame_height <= DIM_RESET;
    end else if (cfg.valid) begin
      case (mbb_reg_t'(cfg.index))
        REG_CELL_SIDE:    cfg_regs.cell_side    <= cfg.data[3:0];
        REG_BIN_MODE:     cfg_regs.bin_mode     <= mbb_mode_t'(cfg.data[0]);
        REG_FRAME_WIDTH:  cfg_regs.frame_width  <= cfg.data;
        REG_FRAME_HEIGHT: cfg_regs.frame_height <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  mbb_front #(
    .MAX_CELLS_PER_ROW (MAX_CELLS_PER_ROW),
    .MAX_FRAME_WIDTH   (MAX_FRAME_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pix      (pix),
    .cfg_regs (cfg_regs),
    .q_count  (q_count),
    .q_push   (q_push),
    .q_cell   (q_cell),
    .q_pix    (q_pix),
    .q_flags  (q_flags)
  );

  mbb_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_cell_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({q_cell, q_pix, q_flags}),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data),
    .count     (q_count)
  );

  assign {b_cell, b_pix, b_flags} = q_pop_data;

  mbb_back #(
    .MAX_CELLS_PER_ROW (MAX_CELLS_PER_ROW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_regs  (cfg_regs),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_cell  (b_cell),
    .pop_pix   (b_pix),
    .pop_flags (b_flags),
    .res       (res)
  );

`ifndef SYNTHESIS
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count < NW'(QUEUE_DEPTH)))
    else $error("cell queue written while full");

  a_full_queue_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (q_count == NW'(QUEUE_DEPTH)) |-> !pix.ready)
    else $error("pixel accepted while the cell queue is full");

  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !(q_flags.first && q_flags.last))
    else $error("a cell pixel marked both first and last");

  a_dark_is_blue: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.binned_value <= PIX_W'(BLUE_LIMIT)))
      |-> ((res.blue == COLOUR_FULL) && (res.red == '0) && (res.green == '0)))
    else $error("dark cell not shown in blue");
`endif

endmodule

/* test/tb_mosaic_block_binning_top.sv */
// Self-checking testbench for mosaic_block_binning_top: a directed table, a back-pressure
// frame and random register phases, checked against a built-in predictor or the table's
// own expected results. Depends on mbb_pkg and the channel interfaces under hdl.
module tb_mosaic_block_binning_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mbb_pkg::*;

  localparam int RANDOM_PIXELS = 1150;
  localparam int PHASE_CAP     = 200;
  localparam int CALM_TAIL     = 200;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 400;
  localparam int PRESS_WIDTH   = 64;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic {ROW_REG, ROW_PIXEL} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    mbb_reg_t              reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic [PIX_W-1:0]      pixel;
    logic                  start;
    logic                  typed;
    mbb_result_t           want;
  } stim_row_t;

  localparam mbb_result_t NO_RESULT = '0;

  logic clk = 1'b0;
  logic rst;

  mbb_cfg_if cfg_bus ();
  mbb_pix_if pix_bus ();
  mbb_res_if res_bus ();

  mosaic_block_binning_top dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .pix(pix_bus),
    .res(res_bus)
  );

  mbb_cfg_t         reg_shadow;
  logic [ACC_W-1:0] cell_line [MAX_CELLS_PER_ROW];
  int unsigned      col_pos;
  int unsigned      row_pos;
  mbb_result_t      pending_cells [$];
  mbb_result_t      seen;
  mbb_result_t      want_cell;
  stim_row_t        directed_rows [35];

  int fault_count   = 0;
  int cells_checked = 0;
  int pixels_sent   = 0;
  int reg_writes    = 0;
  int phase_count   = 0;
  int tx_gap_pct    = 10;
  int rx_stall_pct  = 10;
  int hold_asks     = 0;
  int holds_done    = 0;
  bit calm          = 1'b0;

  always #10ns clk = ~clk;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic stim_row_t set_reg(mbb_reg_t idx, logic [CFG_DATA_W-1:0] d);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_data = d;
    return r;
  endfunction

  function automatic stim_row_t pixel_row(logic [PIX_W-1:0] px, logic fs);
    stim_row_t r;
    r = '0;
    r.kind = ROW_PIXEL;
    r.pixel = px;
    r.start = fs;
    return r;
  endfunction

  function automatic stim_row_t checked_row(logic [PIX_W-1:0] px, logic fs, mbb_result_t w);
    stim_row_t r;
    r = pixel_row(px, fs);
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  // Folds one pixel into the cell line and returns the cell result it completes, if any.
  function automatic void bin_pixel(input logic [PIX_W-1:0] px, input logic fs,
                                    output bit got, output mbb_result_t r);
    int unsigned side, wid, hgt, cells_w, cells_h, x, y, cell_idx, cx, cy, acc, v, c, g;
    side = clamp_dim(reg_shadow.cell_side, SIDE_MIN, SIDE_MAX);
    wid = clamp_dim(reg_shadow.frame_width, DIM_MIN, MAX_FRAME_WIDTH);
    hgt = clamp_dim(reg_shadow.frame_height, DIM_MIN, HEIGHT_MAX);
    got = 1'b0;
    r = NO_RESULT;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= wid) col_pos = 0;
    if (row_pos >= hgt) row_pos = 0;
    x = col_pos;
    y = row_pos;
    cells_w = wid / side;
    if (cells_w > MAX_CELLS_PER_ROW) cells_w = MAX_CELLS_PER_ROW;
    cells_h = hgt / side;
    cell_idx = x / side;
    cx = x % side;
    cy = y % side;
    if (cell_idx < cells_w && y / side < cells_h) begin
      acc = cell_line[cell_idx];
      if (cx == 0 && cy == 0) begin
        acc = px;
      end else if (reg_shadow.bin_mode == MODE_MAX) begin
        if (px > acc) acc = px;
      end else begin
        acc = (acc + px) % (1 << ACC_W);
      end
      cell_line[cell_idx] = ACC_W'(acc);
      if (cx == side - 1 && cy == side - 1) begin
        if (reg_shadow.bin_mode == MODE_MAX) v = acc;
        else v = acc / (side * side);
        if (v > VALUE_MAX) v = VALUE_MAX;
        c = (v > COLOUR_CLIP) ? COLOUR_CLIP : v;
        g = c * COLOUR_FULL / COLOUR_CLIP;
        r.binned_value = PIX_W'(v);
        if (c <= BLUE_LIMIT) begin
          r.blue = COLOUR_FULL;
        end else if (c >= RED_LIMIT) begin
          r.red = COLOUR_FULL;
        end else begin
          r.red = COLOUR_W'(g);
          r.green = COLOUR_W'(g);
          r.blue = COLOUR_W'(g);
        end
        r.frame_end = (cell_idx == cells_w - 1) && (y / side == cells_h - 1);
        got = 1'b1;
      end
    end
    col_pos = x + 1;
    if (col_pos >= wid) begin
      col_pos = 0;
      row_pos = y + 1;
      if (row_pos >= hgt) row_pos = 0;
    end
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return VALUE_MAX;
      2, 3: return PIX_W'($urandom_range(0, 20));
      4, 5: return PIX_W'($urandom_range(1000, 1030));
      default: return PIX_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [3:0] pick_side();
    int unsigned k;
    if ($urandom_range(0, 6) != 0) return 4'($urandom_range(2, 8));
    k = $urandom_range(0, 8);
    return (k < 2) ? 4'(k) : 4'(k + 7);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim(int unsigned side, int unsigned bands);
    if ($urandom_range(0, 11) == 0) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return CFG_DATA_W'(1);
        2: return '1;
        default: return CFG_DATA_W'($urandom_range(2, 4095));
      endcase
    end
    return CFG_DATA_W'(side * $urandom_range(1, bands) + $urandom_range(0, side - 1));
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 5;
      default: return 25;
    endcase
  endfunction

  task automatic write_reg(mbb_reg_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= d;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      REG_CELL_SIDE:    reg_shadow.cell_side = d[3:0];
      REG_BIN_MODE:     reg_shadow.bin_mode = mbb_mode_t'(d[0]);
      REG_FRAME_WIDTH:  reg_shadow.frame_width = d;
      REG_FRAME_HEIGHT: reg_shadow.frame_height = d;
      default: begin
      end
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] px, logic fs, bit typed, mbb_result_t w);
    bit got;
    mbb_result_t predicted;
    cfg_bus.valid <= 1'b0;
    pix_bus.valid <= 1'b1;
    pix_bus.pixel_value <= px;
    pix_bus.frame_start <= fs;
    do @(posedge clk); while (pix_bus.ready !== 1'b1);
    bin_pixel(px, fs, got, predicted);
    if (typed) pending_cells.push_back(w);
    else if (got) pending_cells.push_back(predicted);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
      pix_bus.valid <= 1'b0;
      cfg_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  // Pixels that complete no cell may still be in flight once the queue is empty.
  task automatic wait_idle();
    pix_bus.valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != holds_done) begin
        res_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        holds_done++;
        res_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        res_bus.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
        res_bus.ready <= 1'b0;
        stall_left = $urandom_range(0, 15);
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      seen.binned_value = res_bus.binned_value;
      seen.red = res_bus.red;
      seen.green = res_bus.green;
      seen.blue = res_bus.blue;
      seen.frame_end = res_bus.frame_end;
      if (pending_cells.size() == 0) begin
        if (fault_count < REPORT_LIMIT)
          $display("%0t: unexpected cell item: value %0d rgb %0d/%0d/%0d end %0b", $realtime,
                   seen.binned_value, seen.red, seen.green, seen.blue, seen.frame_end);
        fault_count++;
      end else begin
        want_cell = pending_cells.pop_front();
        cells_checked++;
        if (seen.binned_value !== want_cell.binned_value || seen.red !== want_cell.red ||
            seen.green !== want_cell.green || seen.blue !== want_cell.blue ||
            seen.frame_end !== want_cell.frame_end) begin
          if (fault_count < REPORT_LIMIT)
            $display("%0t: cell %0d expected %0d rgb %0d/%0d/%0d end %0b, got %0d rgb %0d/%0d/%0d end %0b",
                     $realtime, cells_checked, want_cell.binned_value, want_cell.red,
                     want_cell.green, want_cell.blue, want_cell.frame_end, seen.binned_value,
                     seen.red, seen.green, seen.blue, seen.frame_end);
          fault_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("[mosaic_block_binning_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    bit          prev_pixel;
    bit          fresh;
    logic        fs;
    int unsigned rand_done;
    int unsigned count;
    int unsigned frame_px;
    int unsigned side_now;
    rst = 1'b1;
    pix_bus.valid = 1'b0;
    pix_bus.pixel_value = '0;
    pix_bus.frame_start = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_CELL_SIDE;
    cfg_bus.data = '0;
    reg_shadow = '{cell_side: SIDE_RESET, bin_mode: MODE_MAX,
                   frame_width: DIM_RESET, frame_height: DIM_RESET};
    foreach (cell_line[k]) cell_line[k] = '0;
    col_pos = 0;
    row_pos = 0;
    prev_pixel = 1'b0;
    rand_done = 0;

    directed_rows = '{
      set_reg(REG_CELL_SIDE, 12'd2),
      set_reg(REG_BIN_MODE, 12'(MODE_MAX)),
      set_reg(REG_FRAME_WIDTH, 12'd2),
      set_reg(REG_FRAME_HEIGHT, 12'd2),
      pixel_row(16'd0, 1'b1),
      pixel_row(16'd0, 1'b0),
      pixel_row(16'd0, 1'b0),
      checked_row(16'd0, 1'b0, '{16'd0, 8'd0, 8'd0, 8'd255, 1'b1}),
      pixel_row(16'd65535, 1'b0),
      pixel_row(16'd1, 1'b0),
      pixel_row(16'd2, 1'b0),
      checked_row(16'd3, 1'b0, '{16'd65535, 8'd255, 8'd0, 8'd0, 1'b1}),
      set_reg(REG_BIN_MODE, 12'(MODE_MEAN)),
      pixel_row(16'd65535, 1'b1),
      pixel_row(16'd65535, 1'b0),
      pixel_row(16'd65535, 1'b0),
      checked_row(16'd65534, 1'b0, '{16'd65534, 8'd255, 8'd0, 8'd0, 1'b1}),
      pixel_row(16'd65535, 1'b1),
      pixel_row(16'd65535, 1'b0),
      pixel_row(16'd65535, 1'b0),
      set_reg(REG_BIN_MODE, 12'(MODE_MAX)),
      checked_row(16'd0, 1'b0, '{16'd65535, 8'd255, 8'd0, 8'd0, 1'b1}),
      set_reg(REG_CELL_SIDE, 12'd0),
      set_reg(REG_FRAME_WIDTH, 12'd1),
      set_reg(REG_FRAME_HEIGHT, 12'd0),
      set_reg(REG_BIN_MODE, 12'(MODE_MEAN)),
      pixel_row(16'd20, 1'b1),
      pixel_row(16'd21, 1'b0),
      pixel_row(16'd22, 1'b0),
      pixel_row(16'd23, 1'b0),
      pixel_row(16'd7, 1'b1),
      pixel_row(16'd9, 1'b1),
      pixel_row(16'd11, 1'b0),
      pixel_row(16'd13, 1'b0),
      pixel_row(16'd15, 1'b0)
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        if (prev_pixel) wait_idle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
        prev_pixel = 1'b0;
      end else begin
        maybe_gap();
        send_pixel(directed_rows[i].pixel, directed_rows[i].start, directed_rows[i].typed,
                   directed_rows[i].want);
        prev_pixel = 1'b1;
      end
    end

    // Two pixel rows forming one row of small cells, with the output held off during the second
    // pixel row, so that the result buffer and the cell queue fill up and the input stalls.
    wait_idle();
    write_reg(REG_CELL_SIDE, 12'd2);
    write_reg(REG_BIN_MODE, 12'(MODE_MEAN));
    write_reg(REG_FRAME_WIDTH, 12'(PRESS_WIDTH));
    write_reg(REG_FRAME_HEIGHT, 12'd2);
    tx_gap_pct = 0;
    rx_stall_pct = 5;
    for (int unsigned i = 0; i < 2 * PRESS_WIDTH; i++) begin
      if (i == PRESS_WIDTH + 10) hold_asks++;
      send_pixel(pick_pixel(), i == 0, 1'b0, NO_RESULT);
    end

    while (rand_done < RANDOM_PIXELS) begin
      wait_idle();
      phase_count++;
      calm = (rand_done >= RANDOM_PIXELS - CALM_TAIL);
      tx_gap_pct = pick_pct();
      rx_stall_pct = pick_pct();
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_CELL_SIDE, {8'($urandom), pick_side()});
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_BIN_MODE, {11'($urandom), 1'($urandom)});
      side_now = clamp_dim(reg_shadow.cell_side, SIDE_MIN, SIDE_MAX);
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_WIDTH, pick_dim(side_now, 5));
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_HEIGHT, pick_dim(side_now, 4));
      frame_px = clamp_dim(reg_shadow.frame_width, DIM_MIN, MAX_FRAME_WIDTH) *
                 clamp_dim(reg_shadow.frame_height, DIM_MIN, HEIGHT_MAX);
      count = frame_px * $urandom_range(1, 3);
      if (count > PHASE_CAP) count = $urandom_range(20, PHASE_CAP);
      fresh = ($urandom_range(0, 3) != 0);
      for (int unsigned i = 0; i < count; i++) begin
        maybe_gap();
        fs = (fresh && i % frame_px == 0) || ($urandom_range(0, 149) == 0);
        send_pixel(pick_pixel(), fs, 1'b0, NO_RESULT);
      end
      rand_done += count;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d pixels and checked %0d cells over %0d register writes and %0d random phases,",
             pixels_sent, cells_checked, reg_writes, phase_count);
    $display("with a back-pressure frame and one long output hold-off.");
    if (fault_count == 0) begin
      $display("[mosaic_block_binning_top] OK");
    end else begin
      $display("%0d mismatches in total", fault_count);
      $display("[mosaic_block_binning_top] ERROR");
    end
    $finish;
  end

endmodule
